/* rtl/wor_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the window outlier rejection block
package wor_pkg;

   // window geometry
   localparam int WIN_LEN   = 5;
   localparam int WIN_DEPTH = WIN_LEN - 1;
   localparam int WIN_HALF  = WIN_LEN / 2;
   localparam int CNT_W     = 3;

   // arithmetic widths
   localparam int DATA_W = 32;
   localparam int SUM_W  = 35;   // sum of five 32-bit values
   localparam int DIF_W  = 36;   // five times a value minus the sum
   localparam int MAG_W  = 35;   // magnitude of that difference, at most 2^34
   localparam int LO_W   = 18;   // low part of a magnitude for the split multiply
   localparam int HI_W   = MAG_W - LO_W;
   localparam int HH_W   = 2 * HI_W;
   localparam int HL_W   = HI_W + LO_W;
   localparam int LL_W   = 2 * LO_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int ACC_W  = SQ_W + 2;

   // pipeline depth ahead of the emit stage
   localparam int NUM_STG = 7;

   // emit slots, in the order results leave
   localparam int SLOT_FIRST = 0;
   localparam int SLOT_TAIL  = 1;
   localparam int SLOT_LAST  = 2;
   localparam int NUM_SLOT   = 3;

   // input word
   typedef struct packed {
      logic signed [DATA_W-1:0] sample_time;
      logic signed [DATA_W-1:0] sample_value;
      logic                     end_of_sequence;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [DATA_W-1:0] kept_time;
      logic signed [DATA_W-1:0] kept_value;
      logic                     final_result;
   } rsp_word_type;

   // samples that may leave, plus sequence position, riding along the pipe
   typedef struct packed {
      logic signed [DATA_W-1:0] ctr_time;
      logic signed [DATA_W-1:0] ctr_value;
      logic signed [DATA_W-1:0] top_time;
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] new_time;
      logic signed [DATA_W-1:0] new_value;
      logic [CNT_W-1:0]         seen;
      logic                     last;
   } carry_type;

endpackage

/* rtl/window_outlier_rejection.sv */
`timescale 1ns / 1ps
// Sigma-clipping outlier filter over a sliding five-sample window
//
// Takes one word per cycle and keeps that rate as long as results are taken
// and no end word holds the emit stage. Each word is tested in a
// seven-register pipeline (capture, sum, deviation, split 18-bit multiplies,
// squares, two add levels), followed by the emit stage and the result
// register. The center of every full window is dropped when (5x-S)^2 > 5Q-S^2.
// A word carrying end_of_sequence releases up to three results, one per cycle
// while results are taken, and holds the emit stage until its last result is
// sent, which can stall the input. The first two and last two samples of a
// sequence are always kept; the last one has final_result set.
module window_outlier_rejection (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wor_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wor_pkg::rsp_word_type rsp_data
);
   import wor_pkg::*;

   // window history, newest at the top index
   logic signed [DATA_W-1:0] win_val_ff [WIN_DEPTH];
   logic signed [DATA_W-1:0] win_time_ff [WIN_DEPTH];
   logic [CNT_W-1:0]         seen_ff;
   logic [CNT_W-1:0]         seen_in;

   // pipeline control
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG:0]   adv;
   carry_type          car_ff [NUM_STG];

   // stage data
   logic signed [DATA_W-1:0] x_ff [WIN_LEN];
   logic signed [DATA_W-1:0] x1_ff [WIN_LEN];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic [MAG_W-1:0]         mag_ff [WIN_LEN];
   logic [MAG_W-1:0]         mag_in [WIN_LEN];
   logic [HH_W-1:0]          hh_ff [WIN_LEN];
   logic [HL_W-1:0]          hl_ff [WIN_LEN];
   logic [LL_W-1:0]          ll_ff [WIN_LEN];
   logic [SQ_W-1:0]          sq_ff [WIN_LEN];
   logic [ACC_W-1:0]         p01_ff;
   logic [ACC_W-1:0]         p34_ff;
   logic [ACC_W-1:0]         mid_ff;
   logic [ACC_W-1:0]         lhs_ff;
   logic [ACC_W-1:0]         lhs2_ff;
   logic [ACC_W-1:0]         rhs_ff;

   // emit stage and result register
   logic [NUM_SLOT-1:0]      em_mask_ff;
   logic [NUM_SLOT-1:0]      em_mask_in;
   logic signed [DATA_W-1:0] em_time_ff [NUM_SLOT];
   logic signed [DATA_W-1:0] em_val_ff [NUM_SLOT];
   logic signed [DATA_W-1:0] em_time_in [NUM_SLOT];
   logic signed [DATA_W-1:0] em_val_in [NUM_SLOT];
   logic                     emit_take;
   logic                     rsp_load;
   logic                     outlier;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_word_type             rsp_data_ff;
   rsp_word_type             rsp_data_in;
   carry_type                tail;

   // stall chain: a stage loads when empty or when its successor loads
   always_comb begin
      adv[NUM_STG] = emit_take;
      for (int k = NUM_STG - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   // sequence position, saturating at the window depth and cleared by an end word
   always_comb begin
      if (req_data.end_of_sequence) begin
         seen_in = '0;
      end else if (seen_ff < CNT_W'(WIN_DEPTH)) begin
         seen_in = seen_ff + 1'b1;
      end else begin
         seen_in = CNT_W'(WIN_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req_valid && req_ready) begin
         seen_ff <= seen_in;
      end
   end

   // window shift on every accepted word
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_val_ff[i]  <= win_val_ff[i+1];
            win_time_ff[i] <= win_time_ff[i+1];
         end
         win_val_ff[WIN_DEPTH-1]  <= req_data.sample_value;
         win_time_ff[WIN_DEPTH-1] <= req_data.sample_time;
      end
   end

   // valid bits and carried samples
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         car_ff[0].ctr_time  <= win_time_ff[WIN_HALF];
         car_ff[0].ctr_value <= win_val_ff[WIN_HALF];
         car_ff[0].top_time  <= win_time_ff[WIN_DEPTH-1];
         car_ff[0].top_value <= win_val_ff[WIN_DEPTH-1];
         car_ff[0].new_time  <= req_data.sample_time;
         car_ff[0].new_value <= req_data.sample_value;
         car_ff[0].seen      <= seen_ff;
         car_ff[0].last      <= req_data.end_of_sequence;
      end
      for (int k = 1; k < NUM_STG; k++) begin
         if (adv[k]) begin
            car_ff[k] <= car_ff[k-1];
         end
      end
   end

   // stage 0: capture the full window
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            x_ff[i] <= win_val_ff[i];
         end
         x_ff[WIN_DEPTH] <= req_data.sample_value;
      end
   end

   // stage 1: window sum
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < WIN_LEN; i++) begin
         sum_in = sum_in + {{(SUM_W-DATA_W){x_ff[i][DATA_W-1]}}, x_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sum_ff <= sum_in;
         x1_ff  <= x_ff;
      end
   end

   // stage 2: magnitude of five times each value minus the sum
   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         logic signed [DIF_W-1:0] xe;
         logic signed [DIF_W-1:0] dif;
         xe  = {{(DIF_W-DATA_W){x1_ff[i][DATA_W-1]}}, x1_ff[i]};
         dif = (xe <<< 2) + xe - {sum_ff[SUM_W-1], sum_ff};
         mag_in[i] = dif[DIF_W-1] ? MAG_W'(-dif) : MAG_W'(dif);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         mag_ff <= mag_in;
      end
   end

   // stage 3: partial products of each square
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            hh_ff[i] <= mag_ff[i][MAG_W-1:LO_W] * mag_ff[i][MAG_W-1:LO_W];
            hl_ff[i] <= mag_ff[i][MAG_W-1:LO_W] * mag_ff[i][LO_W-1:0];
            ll_ff[i] <= mag_ff[i][LO_W-1:0] * mag_ff[i][LO_W-1:0];
         end
      end
   end

   // stage 4: assemble squares
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            sq_ff[i] <= (SQ_W'(hh_ff[i]) << (2 * LO_W))
                      + (SQ_W'(hl_ff[i]) << (LO_W + 1))
                      + SQ_W'(ll_ff[i]);
         end
      end
   end

   // stage 5: first add level, and five times the center square
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         p01_ff <= ACC_W'(sq_ff[0]) + ACC_W'(sq_ff[1]);
         p34_ff <= ACC_W'(sq_ff[3]) + ACC_W'(sq_ff[4]);
         mid_ff <= ACC_W'(sq_ff[WIN_HALF]);
         lhs_ff <= (ACC_W'(sq_ff[WIN_HALF]) << 2) + ACC_W'(sq_ff[WIN_HALF]);
      end
   end

   // stage 6: sum of all squared deviations
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rhs_ff  <= p01_ff + p34_ff + mid_ff;
         lhs2_ff <= lhs_ff;
      end
   end

   // decide which samples this word releases
   assign tail     = car_ff[NUM_STG-1];
   assign outlier  = lhs2_ff > rhs_ff;
   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign emit_take = (em_mask_ff == '0)
                    || ($onehot(em_mask_ff) && rsp_load);

   always_comb begin
      em_mask_in = '0;
      em_time_in[SLOT_FIRST] = tail.top_time;
      em_val_in[SLOT_FIRST]  = tail.top_value;
      if (tail.seen == CNT_W'(WIN_DEPTH)) begin
         em_time_in[SLOT_FIRST] = tail.ctr_time;
         em_val_in[SLOT_FIRST]  = tail.ctr_value;
         em_mask_in[SLOT_FIRST] = !outlier;
      end else if (tail.seen != '0 && tail.seen <= CNT_W'(WIN_HALF)) begin
         em_mask_in[SLOT_FIRST] = 1'b1;
      end
      em_time_in[SLOT_TAIL] = tail.top_time;
      em_val_in[SLOT_TAIL]  = tail.top_value;
      em_mask_in[SLOT_TAIL] = tail.last && (tail.seen > CNT_W'(WIN_HALF));
      em_time_in[SLOT_LAST] = tail.new_time;
      em_val_in[SLOT_LAST]  = tail.new_value;
      em_mask_in[SLOT_LAST] = tail.last;
      if (!vld_ff[NUM_STG-1]) begin
         em_mask_in = '0;
      end
   end

   // pick the oldest pending slot for the result register
   always_comb begin
      rsp_valid_in = em_mask_ff != '0;
      rsp_data_in.kept_time    = em_time_ff[SLOT_LAST];
      rsp_data_in.kept_value   = em_val_ff[SLOT_LAST];
      rsp_data_in.final_result = 1'b1;
      if (em_mask_ff[SLOT_FIRST]) begin
         rsp_data_in.kept_time    = em_time_ff[SLOT_FIRST];
         rsp_data_in.kept_value   = em_val_ff[SLOT_FIRST];
         rsp_data_in.final_result = 1'b0;
      end else if (em_mask_ff[SLOT_TAIL]) begin
         rsp_data_in.kept_time    = em_time_ff[SLOT_TAIL];
         rsp_data_in.kept_value   = em_val_ff[SLOT_TAIL];
         rsp_data_in.final_result = 1'b0;
      end
   end

   // emit stage: load a new word or retire the slot just sent
   always_ff @(posedge clock) begin
      if (reset) begin
         em_mask_ff <= '0;
      end else if (emit_take) begin
         em_mask_ff <= em_mask_in;
      end else if (rsp_load) begin
         em_mask_ff <= em_mask_ff & (em_mask_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (emit_take) begin
         em_time_ff <= em_time_in;
         em_val_ff  <= em_val_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(WIN_DEPTH))
      else $error("sequence position beyond window depth");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_sequence) |=> seen_ff == '0)
      else $error("sequence position not cleared after end word");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      ($countones(em_mask_ff) > 1) |-> !emit_take)
      else $error("emit stage reloaded with results still pending");

   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NUM_STG-1] && !adv[NUM_STG-1])
         |=> vld_ff[NUM_STG-1] && $stable(car_ff[NUM_STG-1]))
      else $error("stalled pipeline word lost or changed");

   a_final_from_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && em_mask_ff == NUM_SLOT'(1 << SLOT_LAST)) |=> rsp_data.final_result)
      else $error("last result of a sequence not marked final");

endmodule
